/* design/ordered_list_store_assert.svh */
// Assertion macros used by the ordered list store RTL.
`ifndef ORDERED_LIST_STORE_ASSERT_SVH
`define ORDERED_LIST_STORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OLST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OLST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/olst_pkg.sv */
// ---------------------------------------------------------------------------
// olst_pkg
// Shared types and constants of the ordered list store: command kinds,
// result status codes, sequencer states and the result beat record.
// ---------------------------------------------------------------------------
package olst_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int VALUE_W      = 32;

   typedef enum logic [1:0] {
      KIND_APPEND   = 2'd0,
      KIND_DELETE   = 2'd1,
      KIND_LIST_FWD = 2'd2,
      KIND_LIST_BWD = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_APPENDED  = 3'd0,
      STAT_DELETED   = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_EMPTY     = 3'd4,
      STAT_LISTED    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EMIT,
      S_SCAN,
      S_LIST
   } state_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  item_value;
      logic                       last;
   } beat_type;

endpackage

/* design/olst_mem.sv */
// ---------------------------------------------------------------------------
// olst_mem
// Entry store: one write port and one read port, read data registered.
// The read register holds its value while no read is issued.
// ---------------------------------------------------------------------------
module olst_mem #(
   parameter int DEPTH = olst_pkg::CAPACITY_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [AW-1:0]                       wr_addr,
   input  logic signed [olst_pkg::VALUE_W-1:0] wr_data,
   input  logic                                rd_en,
   input  logic [AW-1:0]                       rd_addr,
   output logic signed [olst_pkg::VALUE_W-1:0] rd_data
);

   logic signed [olst_pkg::VALUE_W-1:0] store_mem [DEPTH];
   logic signed [olst_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/olst_ctrl.sv */
// ---------------------------------------------------------------------------
// olst_ctrl
// Command sequencer: takes one command, walks the entry store for delete
// and list, compacts the list behind a deleted entry, and hands result
// beats to the output register.
// ---------------------------------------------------------------------------
`include "ordered_list_store_assert.svh"

module olst_ctrl #(
   parameter int CAPACITY = olst_pkg::CAPACITY_DEF,
   localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic signed [olst_pkg::VALUE_W-1:0] req_value,
   input  logic                                out_free,
   output logic                                beat_ld,
   output olst_pkg::beat_type                  beat,
   output logic                                wr_en,
   output logic [AW-1:0]                       wr_addr,
   output logic signed [olst_pkg::VALUE_W-1:0] wr_data,
   output logic                                rd_en,
   output logic [AW-1:0]                       rd_addr,
   input  logic signed [olst_pkg::VALUE_W-1:0] rd_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   olst_pkg::state_type                 state_ff, state_in;
   olst_pkg::status_type                st_ff, st_in;
   logic signed [olst_pkg::VALUE_W-1:0] val_ff, val_in;
   logic                                fwd_ff, fwd_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [CW-1:0]                       rd_cnt_ff, rd_cnt_in;
   logic [CW-1:0]                       em_cnt_ff, em_cnt_in;
   logic                                pend_ff, pend_in;
   logic                                found_ff, found_in;

   logic                                issue;
   logic [CW-1:0]                       sh_idx;
   logic [CW-1:0]                       lst_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= olst_pkg::S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff     <= st_in;
      val_ff    <= val_in;
      fwd_ff    <= fwd_in;
      rd_cnt_ff <= rd_cnt_in;
      em_cnt_ff <= em_cnt_in;
   end

   always_comb begin
      state_in  = state_ff;
      st_in     = st_ff;
      val_in    = val_ff;
      fwd_in    = fwd_ff;
      count_in  = count_ff;
      rd_cnt_in = rd_cnt_ff;
      em_cnt_in = em_cnt_ff;
      pend_in   = pend_ff;
      found_in  = found_ff;
      req_stall = 1'b1;
      beat_ld   = 1'b0;
      beat      = '{status: st_ff, item_value: val_ff, last: 1'b1};
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = req_value;
      rd_en     = 1'b0;
      rd_addr   = rd_cnt_ff[AW-1:0];
      issue     = 1'b0;
      sh_idx    = rd_cnt_ff - CW'(2);
      lst_idx   = count_ff - CW'(1) - rd_cnt_ff;

      unique case (state_ff)
         olst_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               val_in    = req_value;
               fwd_in    = (olst_pkg::kind_type'(req_kind) == olst_pkg::KIND_LIST_FWD);
               rd_cnt_in = '0;
               em_cnt_in = '0;
               pend_in   = 1'b0;
               found_in  = 1'b0;
               unique case (olst_pkg::kind_type'(req_kind))
                  olst_pkg::KIND_APPEND: begin
                     state_in = olst_pkg::S_EMIT;
                     if (count_ff < CW'(CAPACITY)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                        st_in    = olst_pkg::STAT_APPENDED;
                     end else begin
                        st_in = olst_pkg::STAT_FULL;
                     end
                  end
                  olst_pkg::KIND_DELETE: begin
                     state_in = olst_pkg::S_SCAN;
                  end
                  olst_pkg::KIND_LIST_FWD, olst_pkg::KIND_LIST_BWD: begin
                     if (count_ff == '0) begin
                        st_in    = olst_pkg::STAT_EMPTY;
                        val_in   = '0;
                        state_in = olst_pkg::S_EMIT;
                     end else begin
                        state_in = olst_pkg::S_LIST;
                     end
                  end
                  default: begin
                     state_in = olst_pkg::S_IDLE;
                  end
               endcase
            end
         end

         olst_pkg::S_EMIT: begin
            if (out_free) begin
               beat_ld  = 1'b1;
               state_in = olst_pkg::S_IDLE;
            end
         end

         // Read ahead one entry per cycle; once the match is seen, copy
         // each later entry down by one slot.
         olst_pkg::S_SCAN: begin
            issue     = (rd_cnt_ff < count_ff);
            rd_en     = issue;
            rd_cnt_in = rd_cnt_ff + CW'(issue);
            pend_in   = issue;
            if (pend_ff) begin
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = sh_idx[AW-1:0];
                  wr_data = rd_data;
               end else if (rd_data == val_ff) begin
                  found_in = 1'b1;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = olst_pkg::S_EMIT;
               if (found_ff) begin
                  count_in = count_ff - CW'(1);
                  st_in    = olst_pkg::STAT_DELETED;
               end else begin
                  st_in = olst_pkg::STAT_NOT_FOUND;
               end
            end
         end

         // Keep one read in flight; issue the next only as the held one leaves.
         olst_pkg::S_LIST: begin
            beat_ld   = pend_ff && out_free;
            beat      = '{status: olst_pkg::STAT_LISTED, item_value: rd_data,
                          last: (em_cnt_ff == count_ff - CW'(1))};
            issue     = (rd_cnt_ff < count_ff) && (!pend_ff || beat_ld);
            rd_en     = issue;
            rd_addr   = fwd_ff ? rd_cnt_ff[AW-1:0] : lst_idx[AW-1:0];
            rd_cnt_in = rd_cnt_ff + CW'(issue);
            pend_in   = issue || (pend_ff && !beat_ld);
            if (beat_ld) begin
               em_cnt_in = em_cnt_ff + CW'(1);
               if (beat.last) begin
                  state_in = olst_pkg::S_IDLE;
               end
            end
         end

         default: begin
            state_in = olst_pkg::S_IDLE;
         end
      endcase
   end

   `OLST_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "entry count above capacity")
   `OLST_ASSERT_SAME(a_ld_free, clock, reset, beat_ld, out_free, "beat loaded into a busy output register")
   `OLST_ASSERT_SAME(a_port_clash, clock, reset, wr_en && rd_en, wr_addr != rd_addr, "read and write hit the same entry")
   `OLST_ASSERT_SAME(a_shift_found, clock, reset, wr_en && (state_ff == olst_pkg::S_SCAN), found_ff, "compaction write before a match")
   `OLST_ASSERT_NEXT(a_emit_done, clock, reset, beat_ld && (state_ff == olst_pkg::S_EMIT), state_ff == olst_pkg::S_IDLE, "single result did not end the command")

endmodule

/* design/ordered_list_store.sv */
// ---------------------------------------------------------------------------
// ordered_list_store
// Ordered list of signed 32-bit values with append, delete by value and
// forward or backward listing.
//   req_ channel carries one command (req_kind, req_value) per beat; rsp_
//   returns result beats (rsp_status, rsp_item_value, rsp_last), and
//   rsp_last marks the final beat of a command.
//   One command is in flight at a time; req_stall stays high until the
//   command's last result beat is loaded into the output register.
//   Append and list of an empty store: one result beat.
//   Delete: a scan through the entry memory, copying the entries behind the
//   match down in the same pass, then one beat.
//   List: one memory read per beat through the single read port, so count
//   beats; a new read issues only as the held beat is loaded.
//   While rsp_stall is high the output register holds its beat and a list
//   walk pauses; nothing is dropped. Synchronous reset empties the list.
// ---------------------------------------------------------------------------
module ordered_list_store #(
   parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic signed [olst_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_status,
   output logic signed [olst_pkg::VALUE_W-1:0] rsp_item_value,
   output logic                                rsp_last
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                                out_free;
   logic                                beat_ld;
   olst_pkg::beat_type                  beat;
   logic                                wr_en;
   logic [AW-1:0]                       wr_addr;
   logic signed [olst_pkg::VALUE_W-1:0] wr_data;
   logic                                rd_en;
   logic [AW-1:0]                       rd_addr;
   logic signed [olst_pkg::VALUE_W-1:0] rd_data;

   logic                                rsp_valid_ff, rsp_valid_in;
   olst_pkg::beat_type                  rsp_beat_ff, rsp_beat_in;

   olst_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_value (req_value),
      .out_free  (out_free),
      .beat_ld   (beat_ld),
      .beat      (beat),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   olst_mem #(
      .DEPTH (CAPACITY)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: take a new beat when empty or when the held one leaves.
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (beat_ld) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = beat;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_beat_ff.status;
   assign rsp_item_value = rsp_beat_ff.item_value;
   assign rsp_last       = rsp_beat_ff.last;

endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for ordered_list_store. It runs directed commands on
// an empty list, on a small list with duplicates and on a full list. Random
// traffic follows under several idle and stall mixes, plus a long output
// hold-off. Each accepted command updates a queue model of the list. The
// model pushes the result beats it expects, and every beat on the rsp_
// channel is compared against the oldest one.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY       = olst_pkg::CAPACITY_DEF;
   localparam int VALUE_W        = olst_pkg::VALUE_W;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = CAPACITY + 8;
   localparam int POOL_SIZE      = 12;
   localparam int MIX_ITEMS      = 55;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_kind  = olst_pkg::KIND_APPEND;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [2:0]                rsp_status;
   logic signed [VALUE_W-1:0] rsp_item_value;
   logic                      rsp_last;

   // list contents, head first, and the result beats still owed by the block
   logic signed [VALUE_W-1:0] stored_values[$];
   olst_pkg::beat_type        awaited_beats[$];
   logic signed [VALUE_W-1:0] value_pool[POOL_SIZE];

   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_taken    = 0;
   int hold_left     = 0;
   int error_count   = 0;
   int beats_checked = 0;
   int full_hits     = 0;
   int miss_hits     = 0;
   int max_fill      = 0;
   int kind_counts[4] = '{0, 0, 0, 0};

   ordered_list_store dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_item_value (rsp_item_value),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // list model
   // -------------------------------------------------------------------------
   function automatic void predict_command(input olst_pkg::kind_type kind,
                                           input logic signed [VALUE_W-1:0] value);
      int hit;
      int count;
      hit   = -1;
      count = stored_values.size();
      unique case (kind)
         olst_pkg::KIND_APPEND: begin
            if (count >= CAPACITY) begin
               awaited_beats.push_back(
                  olst_pkg::beat_type'{olst_pkg::STAT_FULL, value, 1'b1});
               full_hits++;
            end else begin
               stored_values.push_back(value);
               awaited_beats.push_back(
                  olst_pkg::beat_type'{olst_pkg::STAT_APPENDED, value, 1'b1});
            end
         end
         olst_pkg::KIND_DELETE: begin
            foreach (stored_values[i])
               if (hit < 0 && stored_values[i] == value) hit = i;
            if (hit < 0) begin
               awaited_beats.push_back(
                  olst_pkg::beat_type'{olst_pkg::STAT_NOT_FOUND, value, 1'b1});
               miss_hits++;
            end else begin
               stored_values.delete(hit);
               awaited_beats.push_back(
                  olst_pkg::beat_type'{olst_pkg::STAT_DELETED, value, 1'b1});
            end
         end
         default: begin
            if (count == 0)
               awaited_beats.push_back(
                  olst_pkg::beat_type'{olst_pkg::STAT_EMPTY, '0, 1'b1});
            for (int i = 0; i < count; i++)
               awaited_beats.push_back(olst_pkg::beat_type'{olst_pkg::STAT_LISTED,
                  stored_values[(kind == olst_pkg::KIND_LIST_FWD) ? i : count - 1 - i],
                  (i == count - 1)});
         end
      endcase
      if (stored_values.size() > max_fill) max_fill = stored_values.size();
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      // favor a small pool so deletes find duplicates and hits
      if ($urandom_range(0, 99) < 55) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------
   task automatic send_command(input olst_pkg::kind_type kind,
                               input logic signed [VALUE_W-1:0] value);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      predict_command(kind, value);
      kind_counts[kind]++;
   endtask

   // call right after the last send: drop valid and let all owed beats arrive
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // response side
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_taken != hold_requests) begin
         hold_taken = hold_requests;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_beat
      olst_pkg::beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_beats.size() == 0) begin
            error_count++;
            $display("%0t: unexpected beat: status %0d value %0d last %0b",
                     $time, rsp_status, rsp_item_value, rsp_last);
         end else begin
            want = awaited_beats.pop_front();
            beats_checked++;
            if (rsp_status !== want.status || rsp_item_value !== want.item_value ||
                rsp_last !== want.last) begin
               error_count++;
               $display("%0t: mismatch: expected %0d/%0d/%0b, actual %0d/%0d/%0b",
                        $time, want.status, want.item_value, want.last,
                        rsp_status, rsp_item_value, rsp_last);
            end
         end
      end
   end

   // end the run if neither channel moves a beat for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("ordered_list_store verification failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------
   task automatic test_empty_list();
      send_command(olst_pkg::KIND_LIST_FWD, VALUE_MAX);
      send_command(olst_pkg::KIND_LIST_BWD, VALUE_MIN);
      send_command(olst_pkg::KIND_DELETE, VALUE_MIN);
      wait_for_results();
   endtask

   task automatic test_append_delete();
      send_command(olst_pkg::KIND_APPEND, VALUE_MIN);
      send_command(olst_pkg::KIND_APPEND, VALUE_MAX);
      send_command(olst_pkg::KIND_APPEND, '0);
      send_command(olst_pkg::KIND_APPEND, -1);
      send_command(olst_pkg::KIND_APPEND, 5);
      send_command(olst_pkg::KIND_APPEND, 5);
      send_command(olst_pkg::KIND_APPEND, 7);
      send_command(olst_pkg::KIND_APPEND, 5);
      send_command(olst_pkg::KIND_LIST_FWD, '0);
      send_command(olst_pkg::KIND_LIST_BWD, -1);
      // first of several matches goes, then a miss, then the head
      send_command(olst_pkg::KIND_DELETE, 5);
      send_command(olst_pkg::KIND_DELETE, 42);
      send_command(olst_pkg::KIND_DELETE, VALUE_MIN);
      send_command(olst_pkg::KIND_DELETE, 5);
      send_command(olst_pkg::KIND_LIST_FWD, VALUE_MIN);
      send_command(olst_pkg::KIND_LIST_BWD, VALUE_MAX);
      wait_for_results();
   endtask

   task automatic test_full_list();
      while (stored_values.size() < CAPACITY)
         send_command(olst_pkg::KIND_APPEND, pick_value());
      send_command(olst_pkg::KIND_APPEND, VALUE_MAX);
      send_command(olst_pkg::KIND_LIST_FWD, $urandom);
      send_command(olst_pkg::KIND_LIST_BWD, $urandom);
      send_command(olst_pkg::KIND_DELETE, stored_values[CAPACITY / 2]);
      send_command(olst_pkg::KIND_APPEND, VALUE_MIN);
      send_command(olst_pkg::KIND_DELETE, stored_values[CAPACITY - 1]);
      send_command(olst_pkg::KIND_LIST_FWD, '0);
      // drain the list in random order
      while (stored_values.size() != 0)
         send_command(olst_pkg::KIND_DELETE,
                      stored_values[$urandom_range(0, stored_values.size() - 1)]);
      wait_for_results();
   endtask

   task automatic test_random_mix(input int count);
      int                        roll;
      olst_pkg::kind_type        kind;
      logic signed [VALUE_W-1:0] value;
      for (int n = 0; n < count; n++) begin
         roll  = $urandom_range(0, 99);
         value = pick_value();
         if (roll < 42) begin
            kind = olst_pkg::KIND_APPEND;
         end else if (roll < 76) begin
            kind = olst_pkg::KIND_DELETE;
            if (stored_values.size() != 0 && $urandom_range(0, 99) < 70)
               value = stored_values[$urandom_range(0, stored_values.size() - 1)];
         end else if (roll < 88) begin
            kind = olst_pkg::KIND_LIST_FWD;
         end else begin
            kind = olst_pkg::KIND_LIST_BWD;
         end
         send_command(kind, value);
      end
      wait_for_results();
   endtask

   task automatic test_backpressure();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      // hold the output while commands keep coming, so the input stalls
      hold_requests++;
      for (int n = 0; n < 12; n++) send_command(olst_pkg::KIND_APPEND, pick_value());
      send_command(olst_pkg::KIND_LIST_BWD, '0);
      send_command(olst_pkg::KIND_DELETE, stored_values[0]);
      wait_for_results();
      send_command(olst_pkg::KIND_LIST_FWD, '0);
      wait_for_results();
   endtask

   // -------------------------------------------------------------------------
   // sequence
   // -------------------------------------------------------------------------
   initial begin
      value_pool[0] = VALUE_MIN;
      value_pool[1] = VALUE_MAX;
      value_pool[2] = '0;
      value_pool[3] = -1;
      value_pool[4] = 1;
      for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom;

      send_gap_pct  = 18;
      rsp_stall_pct = 61;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_append_delete();
      test_full_list();
      test_random_mix(MIX_ITEMS);

      send_gap_pct  = 61;
      rsp_stall_pct = 18;
      test_random_mix(MIX_ITEMS);

      test_backpressure();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      test_random_mix(MIX_ITEMS);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d commands: %0d appends, %0d deletes, %0d fwd, %0d bwd lists",
               kind_counts[olst_pkg::KIND_APPEND] + kind_counts[olst_pkg::KIND_DELETE] +
               kind_counts[olst_pkg::KIND_LIST_FWD] + kind_counts[olst_pkg::KIND_LIST_BWD],
               kind_counts[olst_pkg::KIND_APPEND], kind_counts[olst_pkg::KIND_DELETE],
               kind_counts[olst_pkg::KIND_LIST_FWD], kind_counts[olst_pkg::KIND_LIST_BWD]);
      $display("%0d beats compared, %0d full refusals, %0d misses, peak fill %0d of %0d",
               beats_checked, full_hits, miss_hits, max_fill, CAPACITY);
      if (error_count == 0) begin
         $display("ordered_list_store verification clean");
      end else begin
         $display("ordered_list_store verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/olst_pkg.sv
design/olst_mem.sv
design/olst_ctrl.sv
design/ordered_list_store.sv
tb/testbench.sv
